### hw/rtl/mmb_pkg.sv
`default_nettype none

package mmb_pkg;

    localparam int APB_ADDR_W = 5;

    localparam logic [1:0] KIND_FETCH = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_LOAD  = 2'd3;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_BAD  = 2'd3;

    localparam logic [1:0] FAULT_OK      = 2'd0;
    localparam logic [1:0] FAULT_ADDR    = 2'd1;
    localparam logic [1:0] FAULT_CONSOLE = 2'd2;

    localparam logic [31:0] EOF_BYTE = 32'h0000_00FF;
    localparam logic [31:0] EOF_HALF = 32'h0000_FFFF;
    localparam logic [31:0] EOF_WORD = 32'hFFFF_FFFF;

    localparam logic [2:0] REG_CODE_ORG = 3'd0;
    localparam logic [2:0] REG_RAM_ORG  = 3'd1;
    localparam logic [2:0] REG_CIN_ORG  = 3'd2;
    localparam logic [2:0] REG_CIN_LEN  = 3'd3;
    localparam logic [2:0] REG_COUT_ORG = 3'd4;
    localparam logic [2:0] REG_COUT_LEN = 3'd5;

    localparam logic [31:0] RST_CODE_ORG = 32'h1000_0000;
    localparam logic [31:0] RST_RAM_ORG  = 32'h2000_0000;
    localparam logic [31:0] RST_CIN_ORG  = 32'h3000_0000;
    localparam logic [4:0]  RST_CIN_LEN  = 5'd4;
    localparam logic [31:0] RST_COUT_ORG = 32'h3000_0004;
    localparam logic [4:0]  RST_COUT_LEN = 5'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  access_size;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [7:0]  char_in;
        logic        char_eof;
        logic        console_error;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  fault;
        logic        char_out_valid;
        logic [7:0]  char_out;
        logic        char_taken;
    } out_item_t;

    typedef struct packed {
        logic [31:0] code_org;
        logic [31:0] ram_org;
        logic [31:0] cin_org;
        logic [4:0]  cin_len;
        logic [31:0] cout_org;
        logic [4:0]  cout_len;
    } cfg_t;

endpackage

`default_nettype wire

### hw/rtl/mmb_ram.sv
`default_nettype none

module mmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/mmb_region_cmp.sv
`default_nettype none

module mmb_region_cmp (
    input  logic [31:0] addr,
    input  logic [31:0] base,
    input  logic [31:0] limit,
    output logic [31:0] offset,
    output logic        hit
);

    // offset wraps modulo 2^32, hit when it falls below the limit
    assign offset = addr - base;
    assign hit    = offset < limit;

endmodule

`default_nettype wire

### hw/rtl/mmb_seq.sv
`default_nettype none

module mmb_seq #(
    parameter int DATA_BYTES  = 65536,
    parameter int INSTR_BYTES = 16384
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mmb_pkg::cfg_t      cfg,
    input  logic               start,
    input  mmb_pkg::in_item_t  item,
    output logic               idle,
    output logic               res_valid,
    input  logic               res_ready,
    output mmb_pkg::out_item_t res
);

    import mmb_pkg::*;

    localparam int CLR_DEPTH = (DATA_BYTES > INSTR_BYTES) ? DATA_BYTES : INSTR_BYTES;
    localparam int OFF_W     = $clog2(CLR_DEPTH);
    localparam int DA_W      = $clog2(DATA_BYTES);
    localparam int IA_W      = $clog2(INSTR_BYTES);

    localparam logic [31:0] DATA_LIM_B  = 32'(DATA_BYTES);
    localparam logic [31:0] DATA_LIM_H  = 32'(DATA_BYTES - 1);
    localparam logic [31:0] DATA_LIM_W  = 32'(DATA_BYTES - 3);
    localparam logic [31:0] INSTR_LIM_B = 32'(INSTR_BYTES);
    localparam logic [31:0] INSTR_LIM_H = 32'(INSTR_BYTES - 1);
    localparam logic [31:0] INSTR_LIM_W = 32'(INSTR_BYTES - 3);
    localparam logic [OFF_W-1:0] CLR_LAST = OFF_W'(CLR_DEPTH - 1);

    typedef enum logic [8:0] {
        ST_CLEAR     = 9'b0_0000_0001,
        ST_IDLE      = 9'b0_0000_0010,
        ST_CHK_DATA  = 9'b0_0000_0100,
        ST_CHK_CON   = 9'b0_0000_1000,
        ST_CHK_INSTR = 9'b0_0001_0000,
        ST_RD_ADDR   = 9'b0_0010_0000,
        ST_RD_DATA   = 9'b0_0100_0000,
        ST_WR        = 9'b0_1000_0000,
        ST_DONE      = 9'b1_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [OFF_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [1:0]       cnt_reg, cnt_next;
    in_item_t         item_reg, item_next;
    logic [1:0]       size_reg, size_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic             sel_instr_reg, sel_instr_next;
    logic [31:0]      wsh_reg, wsh_next;
    out_item_t        res_reg, res_next;

    logic [31:0]      cmp_base;
    logic [31:0]      cmp_limit;
    logic [31:0]      cmp_offset;
    logic             cmp_hit;
    logic [31:0]      data_lim;
    logic [31:0]      instr_lim;
    logic [1:0]       last_idx;
    logic [OFF_W-1:0] byte_off;
    logic             misaligned;

    logic             data_we;
    logic [DA_W-1:0]  data_addr;
    logic [7:0]       data_wdata;
    logic [7:0]       data_rdata;
    logic             instr_we;
    logic [IA_W-1:0]  instr_addr;
    logic [7:0]       instr_wdata;
    logic [7:0]       instr_rdata;
    logic [7:0]       mem_byte;

    mmb_region_cmp u_cmp (
        .addr   (item_reg.address),
        .base   (cmp_base),
        .limit  (cmp_limit),
        .offset (cmp_offset),
        .hit    (cmp_hit)
    );

    mmb_ram #(
        .WIDTH (8),
        .DEPTH (DATA_BYTES)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .addr  (data_addr),
        .wdata (data_wdata),
        .rdata (data_rdata)
    );

    mmb_ram #(
        .WIDTH (8),
        .DEPTH (INSTR_BYTES)
    ) u_instr_ram (
        .clk   (clk),
        .we    (instr_we),
        .addr  (instr_addr),
        .wdata (instr_wdata),
        .rdata (instr_rdata)
    );

    // region limits: whole access must fit, so limit is size - n + 1
    always_comb
    begin
        unique case (size_reg)
            SIZE_HALF:
            begin
                data_lim  = DATA_LIM_H;
                instr_lim = INSTR_LIM_H;
                last_idx  = 2'd1;
            end
            SIZE_WORD:
            begin
                data_lim  = DATA_LIM_W;
                instr_lim = INSTR_LIM_W;
                last_idx  = 2'd3;
            end
            default:
            begin
                data_lim  = DATA_LIM_B;
                instr_lim = INSTR_LIM_B;
                last_idx  = 2'd0;
            end
        endcase
    end

    always_comb
    begin
        cmp_base  = cfg.ram_org;
        cmp_limit = data_lim;
        unique case (state_reg)
            ST_CHK_CON:
            begin
                if (item_reg.kind == KIND_READ)
                begin
                    cmp_base  = cfg.cin_org;
                    cmp_limit = (size_reg == SIZE_WORD) ? 32'd1
                                                        : {27'd0, cfg.cin_len};
                end
                else
                begin
                    cmp_base  = cfg.cout_org;
                    cmp_limit = {27'd0, cfg.cout_len};
                end
            end
            ST_CHK_INSTR:
            begin
                if (item_reg.kind == KIND_LOAD)
                begin
                    cmp_base  = 32'd0;
                    cmp_limit = INSTR_LIM_B;
                end
                else
                begin
                    cmp_base  = cfg.code_org;
                    cmp_limit = instr_lim;
                end
            end
            default:
            begin
                cmp_base  = cfg.ram_org;
                cmp_limit = data_lim;
            end
        endcase
    end

    assign byte_off = off_reg + OFF_W'(cnt_reg);

    // memory ports
    always_comb
    begin
        data_we     = ((state_reg == ST_CLEAR) && (32'(clr_cnt_reg) < DATA_LIM_B))
                      || ((state_reg == ST_WR) && !sel_instr_reg);
        instr_we    = ((state_reg == ST_CLEAR) && (32'(clr_cnt_reg) < INSTR_LIM_B))
                      || ((state_reg == ST_WR) && sel_instr_reg);
        data_addr   = (state_reg == ST_CLEAR) ? clr_cnt_reg[DA_W-1:0] : byte_off[DA_W-1:0];
        instr_addr  = (state_reg == ST_CLEAR) ? clr_cnt_reg[IA_W-1:0] : byte_off[IA_W-1:0];
        data_wdata  = (state_reg == ST_CLEAR) ? 8'd0 : wsh_reg[31:24];
        instr_wdata = (state_reg == ST_CLEAR) ? 8'd0 : wsh_reg[31:24];
        mem_byte    = sel_instr_reg ? instr_rdata : data_rdata;
    end

    assign misaligned = (item.access_size == SIZE_BAD)
                        || ((item.access_size == SIZE_HALF) && item.address[0])
                        || ((item.access_size == SIZE_WORD) && (item.address[1:0] != 2'd0));

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cnt_next       = cnt_reg;
        item_next      = item_reg;
        size_next      = size_reg;
        off_next       = off_reg;
        sel_instr_next = sel_instr_reg;
        wsh_next       = wsh_reg;
        res_next       = res_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    cnt_next  = 2'd0;
                    res_next  = '0;
                    size_next = item.access_size;
                    unique case (item.access_size)
                        SIZE_WORD: wsh_next = item.write_data;
                        SIZE_HALF: wsh_next = {item.write_data[15:0], 16'd0};
                        default:   wsh_next = {item.write_data[7:0], 24'd0};
                    endcase
                    unique case (item.kind)
                        KIND_FETCH:
                        begin
                            size_next = SIZE_WORD;
                            if (item.address[1:0] != 2'd0)
                            begin
                                res_next.fault = FAULT_ADDR;
                                state_next     = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_CHK_INSTR;
                            end
                        end
                        KIND_LOAD:
                        begin
                            size_next  = SIZE_BYTE;
                            wsh_next   = {item.write_data[7:0], 24'd0};
                            state_next = ST_CHK_INSTR;
                        end
                        KIND_READ, KIND_WRITE:
                        begin
                            if (misaligned)
                            begin
                                res_next.fault = FAULT_ADDR;
                                state_next     = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_CHK_DATA;
                            end
                        end
                    endcase
                end
            end
            ST_CHK_DATA:
            begin
                if (cmp_hit)
                begin
                    off_next       = cmp_offset[OFF_W-1:0];
                    sel_instr_next = 1'b0;
                    state_next     = (item_reg.kind == KIND_READ) ? ST_RD_ADDR : ST_WR;
                end
                else
                begin
                    state_next = ST_CHK_CON;
                end
            end
            ST_CHK_CON:
            begin
                if (item_reg.kind == KIND_READ)
                begin
                    if (cmp_hit)
                    begin
                        state_next = ST_DONE;
                        if (item_reg.console_error)
                        begin
                            res_next.fault = FAULT_CONSOLE;
                        end
                        else if (item_reg.char_eof)
                        begin
                            unique case (size_reg)
                                SIZE_WORD: res_next.read_data = EOF_WORD;
                                SIZE_HALF: res_next.read_data = EOF_HALF;
                                default:   res_next.read_data = EOF_BYTE;
                            endcase
                        end
                        else
                        begin
                            res_next.read_data  = {24'd0, item_reg.char_in};
                            res_next.char_taken = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = ST_CHK_INSTR;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                    if (!cmp_hit)
                    begin
                        res_next.fault = FAULT_ADDR;
                    end
                    else if (item_reg.console_error)
                    begin
                        res_next.fault = FAULT_CONSOLE;
                    end
                    else
                    begin
                        res_next.char_out_valid = 1'b1;
                        res_next.char_out       = item_reg.write_data[7:0];
                    end
                end
            end
            ST_CHK_INSTR:
            begin
                if (cmp_hit)
                begin
                    off_next       = cmp_offset[OFF_W-1:0];
                    sel_instr_next = 1'b1;
                    state_next     = (item_reg.kind == KIND_LOAD) ? ST_WR : ST_RD_ADDR;
                end
                else
                begin
                    res_next.fault = FAULT_ADDR;
                    state_next     = ST_DONE;
                end
            end
            ST_RD_ADDR:
            begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                // big-endian: first byte ends up most significant
                res_next.read_data = {res_reg.read_data[23:0], mem_byte};
                if (cnt_reg == last_idx)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_RD_ADDR;
                end
            end
            ST_WR:
            begin
                wsh_next = {wsh_reg[23:0], 8'd0};
                if (cnt_reg == last_idx)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            cnt_reg     <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        size_reg      <= size_next;
        off_reg       <= off_next;
        sel_instr_reg <= sel_instr_next;
        wsh_reg       <= wsh_next;
        res_reg       <= res_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

`ifndef NO_ASSERTIONS
    a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == ST_IDLE)
        else $error("transaction started while busy");

    a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reg.fault != FAULT_OK) |->
        (res_reg.read_data == 32'd0 && !res_reg.char_out_valid && !res_reg.char_taken))
        else $error("faulted result carries data");

    a_taken_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reg.char_taken) |->
        (res_reg.fault == FAULT_OK && !res_reg.char_out_valid))
        else $error("char taken on bad result");

    a_ram_write_window: assert property (@(posedge clk) disable iff (!rst_n)
        (data_we || instr_we) |-> (state_reg == ST_CLEAR || state_reg == ST_WR))
        else $error("memory written outside clear or store");
`endif

endmodule

`default_nettype wire

### hw/rtl/memory_map_bus_with_console_io.sv
// an access that faults on alignment goes straight from the accept to the result; a word read
// from instruction memory first passes three region checks (data, console, instruction),
// then an address state and a data state per byte through the byte-wide memory port
// one transaction at a time, the next accepted once the result is handed over to the
// output register
// reset: both memories swept to zero after rst_n rises, before the first transaction is accepted
`default_nettype none

module memory_map_bus_with_console_io #(
    parameter int DATA_BYTES  = 65536,
    parameter int INSTR_BYTES = 16384
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mmb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  mmb_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output mmb_pkg::out_item_t              out_data
);

    import mmb_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;

    logic       cfg_wr;
    logic [2:0] reg_idx;
    logic       seq_idle;
    logic       start;
    logic       res_valid;
    logic       res_ready;
    out_item_t  res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_CODE_ORG: cfg_next.code_org = pwdata;
                REG_RAM_ORG:  cfg_next.ram_org  = pwdata;
                REG_CIN_ORG:  cfg_next.cin_org  = pwdata;
                REG_CIN_LEN:  cfg_next.cin_len  = pwdata[4:0];
                REG_COUT_ORG: cfg_next.cout_org = pwdata;
                REG_COUT_LEN: cfg_next.cout_len = pwdata[4:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CODE_ORG: prdata = cfg_reg.code_org;
            REG_RAM_ORG:  prdata = cfg_reg.ram_org;
            REG_CIN_ORG:  prdata = cfg_reg.cin_org;
            REG_CIN_LEN:  prdata = {27'd0, cfg_reg.cin_len};
            REG_COUT_ORG: prdata = cfg_reg.cout_org;
            REG_COUT_LEN: prdata = {27'd0, cfg_reg.cout_len};
            default:      prdata = 32'd0;
        endcase
    end

    assign in_stall = !seq_idle;
    assign start    = in_valid && !in_stall;

    mmb_seq #(
        .DATA_BYTES  (DATA_BYTES),
        .INSTR_BYTES (INSTR_BYTES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .start     (start),
        .item      (in_data),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_org <= RST_CODE_ORG;
            cfg_reg.ram_org  <= RST_RAM_ORG;
            cfg_reg.cin_org  <= RST_CIN_ORG;
            cfg_reg.cin_len  <= RST_CIN_LEN;
            cfg_reg.cout_org <= RST_COUT_ORG;
            cfg_reg.cout_len <= RST_COUT_LEN;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
